>>> src/spdsq_pkg.sv
`default_nettype none

package spdsq_pkg;

  localparam int unsigned SINE_POINTS_DEF = 200;
  localparam int unsigned PWM_PERIOD_DEF  = 201;
  localparam int unsigned ROM_SIZE        = 200;

  localparam int unsigned FREQ_W   = 10;
  localparam int unsigned RANGE_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned TICK_W   = 19;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned SUB_W    = 4;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned NUM_W    = 30;
  localparam int unsigned QUO10_W  = 7;

  localparam logic [FREQ_W-1:0] FREQ_MIN   = 10'd100;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = 10'd1000;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 10'd100;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd12;
  localparam logic [SUB_W-1:0]  SUB_DIV_HI = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQ  = 1'b0,
    REG_RANGE = 1'b1
  } cfg_reg_t;

  typedef enum logic [RANGE_W-1:0] {
    RANGE_X1    = 2'd0,
    RANGE_X10   = 2'd1,
    RANGE_X100  = 2'd2,
    RANGE_X1000 = 2'd3
  } range_t;

  localparam logic [DUTY_W-1:0] SINE_ROM [0:ROM_SIZE-1] = '{
    8'd97,  8'd99,  8'd102, 8'd104, 8'd107, 8'd109, 8'd111, 8'd114, 8'd116, 8'd119,
    8'd121, 8'd124, 8'd126, 8'd128, 8'd131, 8'd133, 8'd135, 8'd137, 8'd139, 8'd141,
    8'd144, 8'd146, 8'd147, 8'd149, 8'd151, 8'd153, 8'd155, 8'd157, 8'd158, 8'd160,
    8'd161, 8'd163, 8'd164, 8'd165, 8'd167, 8'd168, 8'd169, 8'd170, 8'd171, 8'd172,
    8'd173, 8'd173, 8'd174, 8'd175, 8'd175, 8'd176, 8'd176, 8'd176, 8'd176, 8'd176,
    8'd177, 8'd176, 8'd176, 8'd176, 8'd176, 8'd176, 8'd175, 8'd175, 8'd174, 8'd173,
    8'd173, 8'd172, 8'd171, 8'd170, 8'd169, 8'd168, 8'd167, 8'd165, 8'd164, 8'd163,
    8'd161, 8'd160, 8'd158, 8'd157, 8'd155, 8'd153, 8'd151, 8'd149, 8'd147, 8'd146,
    8'd144, 8'd141, 8'd139, 8'd137, 8'd135, 8'd133, 8'd131, 8'd128, 8'd126, 8'd124,
    8'd121, 8'd119, 8'd116, 8'd114, 8'd111, 8'd109, 8'd107, 8'd104, 8'd102, 8'd99,
    8'd97,  8'd94,  8'd91,  8'd89,  8'd86,  8'd84,  8'd82,  8'd79,  8'd77,  8'd74,
    8'd72,  8'd69,  8'd67,  8'd65,  8'd62,  8'd60,  8'd58,  8'd56,  8'd54,  8'd52,
    8'd49,  8'd47,  8'd46,  8'd44,  8'd42,  8'd40,  8'd38,  8'd36,  8'd35,  8'd33,
    8'd32,  8'd30,  8'd29,  8'd28,  8'd26,  8'd25,  8'd24,  8'd23,  8'd22,  8'd21,
    8'd20,  8'd20,  8'd19,  8'd18,  8'd18,  8'd17,  8'd17,  8'd17,  8'd17,  8'd17,
    8'd17,  8'd17,  8'd17,  8'd17,  8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd20,
    8'd20,  8'd21,  8'd22,  8'd23,  8'd24,  8'd25,  8'd26,  8'd28,  8'd29,  8'd30,
    8'd32,  8'd33,  8'd35,  8'd36,  8'd38,  8'd40,  8'd42,  8'd44,  8'd46,  8'd47,
    8'd49,  8'd52,  8'd54,  8'd56,  8'd58,  8'd60,  8'd62,  8'd65,  8'd67,  8'd69,
    8'd72,  8'd74,  8'd77,  8'd79,  8'd82,  8'd84,  8'd86,  8'd89,  8'd91,  8'd94
  };

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic clr_start;
    logic k_start;
    logic k_load;
    logic upd;
    logic t_start;
    logic t_eval;
    logic i_start;
    logic i_load;
    logic out_load;
  } spdsq_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic k_valid;
    logic fire;
    logic adv;
    logic div_done;
    logic out_free;
  } spdsq_stat_t;

  function automatic logic [DUTY_W-1:0] sine_at(input logic [STEP_W-1:0] idx);
    logic [DUTY_W-1:0] val;
    if (idx >= STEP_W'(ROM_SIZE)) begin
      val = SINE_ROM[ROM_SIZE-1];
    end else begin
      val = SINE_ROM[idx];
    end
    return val;
  endfunction

  // 800000 times the range factor.
  function automatic logic [NUM_W-1:0] num_for_range(input range_t rng);
    logic [NUM_W-1:0] val;
    unique case (rng)
      RANGE_X1:    val = 30'd800000;
      RANGE_X10:   val = 30'd8000000;
      RANGE_X100:  val = 30'd80000000;
      RANGE_X1000: val = 30'd800000000;
      default:     val = 30'd800000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> src/spdsq_in_if.sv
`default_nettype none

interface spdsq_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

`default_nettype wire

>>> src/spdsq_out_if.sv
`default_nettype none

interface spdsq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       period_start;
  logic [7:0] step_index;

  modport source (output valid, output duty, output period_start, output step_index,
                  input ready);
  modport sink (input valid, input duty, input period_start, input step_index,
                output ready);
endinterface

`default_nettype wire

>>> src/spdsq_cfg_if.sv
`default_nettype none

interface spdsq_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/spdsq_div.sv
`default_nettype none

module spdsq_div #(
  parameter int unsigned DVD_W = 32,
  parameter int unsigned DSR_W = 24,
  parameter int unsigned CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  input  logic [CNT_W-1:0] iters,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] sh_r, sh_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DSR_W:0]   rem_sh;
  logic             ge;

  // Restoring division, one quotient bit per cycle. The dividend arrives
  // left-aligned, so after the given number of steps the shift register
  // holds the quotient right-aligned.
  assign rem_sh = {rem_r, sh_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt  = dividend;
      rem_nxt = '0;
      cnt_nxt = iters;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? DSR_W'(rem_sh - {1'b0, dsr_r}) : DSR_W'(rem_sh);
      sh_nxt  = {sh_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign busy     = run_r;
  assign done     = done_r;
  assign quotient = sh_r;

endmodule

`default_nettype wire

>>> src/spdsq_dp.sv
`default_nettype none

module spdsq_dp #(
  parameter int unsigned SINE_POINTS = spdsq_pkg::SINE_POINTS_DEF,
  parameter int unsigned PWM_PERIOD  = spdsq_pkg::PWM_PERIOD_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spdsq_pkg::spdsq_cmd_t               cmd,
  output spdsq_pkg::spdsq_stat_t              stat,
  input  logic                                cfg_valid,
  input  logic [spdsq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spdsq_pkg::FREQ_W-1:0]        cfg_data,
  output logic                                cfg_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spdsq_pkg::DUTY_W-1:0]        out_duty,
  output logic                                out_period_start,
  output logic [spdsq_pkg::STEP_W-1:0]        out_step_index
);

  import spdsq_pkg::*;

  localparam int unsigned K_MAX  = 800000000 / (PWM_PERIOD * 10);
  localparam int unsigned K_W    = $clog2(K_MAX + 1);
  localparam int unsigned N_W    = $clog2(SINE_POINTS + 1);
  localparam int unsigned ND_W   = N_W + 4;
  localparam int unsigned DEN_W  = $clog2(PWM_PERIOD * 100 + 1);
  localparam int unsigned DSR_W  = (DEN_W > ND_W) ? DEN_W : ND_W;
  localparam int unsigned PROD_W = K_W + STEP_W;
  localparam int unsigned IDX_W  = STEP_W + N_W;
  localparam int unsigned DVD_A  = (NUM_W > PROD_W) ? NUM_W : PROD_W;
  localparam int unsigned DVD_W  = (DVD_A > IDX_W) ? DVD_A : IDX_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W + 1);

  // Configuration registers.
  logic [FREQ_W-1:0]  freq_r;
  range_t             range_r;
  logic [FREQ_W-1:0]  fsat;
  logic [17:0]        fmul;
  logic [QUO10_W-1:0] q_r;
  logic [DEN_W-1:0]   den;

  // Derived period constants.
  logic               k_valid_r;
  logic [K_W-1:0]     k_r;
  logic [N_W-1:0]     n_r;
  logic               d10_r;
  logic [ND_W-1:0]    nd;
  logic [K_W-1:0]     kq;
  logic [K_W-1:0]     k_fix;

  // Sequencer state.
  logic [TICK_W-1:0]  tick_r;
  logic [STEP_W-1:0]  step_r;
  logic [SUB_W-1:0]   sub_r;
  logic [TIME_W-1:0]  time_r;
  logic [DUTY_W-1:0]  duty_r;
  logic [STEP_W-1:0]  next_r;
  logic               start_r;

  logic [TICK_W-1:0]  tc1;
  logic               restart;
  logic               fire;
  logic [STEP_W:0]    next9;
  logic [STEP_W-1:0]  next_val;

  // Divider.
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DSR_W-1:0]   div_dsr;
  logic [CNT_W-1:0]   div_iters;
  logic               div_busy;
  logic               div_done;
  logic [DVD_W-1:0]   quo;
  logic [PROD_W-1:0]  tgt_prod;
  logic [IDX_W-1:0]   idx_prod;
  logic [STEP_W-1:0]  rom_idx;
  logic               adv;

  logic               out_valid_r;
  logic [DUTY_W-1:0]  out_duty_r;
  logic               out_start_r;
  logic [STEP_W-1:0]  out_step_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= FREQ_RESET;
      range_r <= RANGE_X1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FREQ:  freq_r  <= cfg_data;
        REG_RANGE: range_r <= range_t'(cfg_data[RANGE_W-1:0]);
        default:   freq_r  <= freq_r;
      endcase
    end
  end

  // Saturated frequency over ten, by reciprocal multiplication (exact below 1029).
  always_comb begin
    if (freq_r < FREQ_MIN) begin
      fsat = FREQ_MIN;
    end else if (freq_r > FREQ_MAX) begin
      fsat = FREQ_MAX;
    end else begin
      fsat = freq_r;
    end
  end
  assign fmul = 18'(fsat) * 18'd205;

  always_ff @(posedge clk) begin
    q_r <= fmul[17:11];
  end

  assign den = DEN_W'(PWM_PERIOD) * DEN_W'(q_r);

  assign kq    = quo[K_W-1:0];
  assign k_fix = (kq == '0) ? K_W'(1) : kq;
  assign nd    = d10_r ? ((ND_W'(n_r) << 3) + (ND_W'(n_r) << 1)) : ND_W'(n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_valid_r <= 1'b0;
    end else if (cfg_valid) begin
      k_valid_r <= 1'b0;
    end else if (cmd.k_load) begin
      k_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.k_load) begin
      k_r   <= k_fix;
      n_r   <= (k_fix < K_W'(SINE_POINTS)) ? N_W'(k_fix) : N_W'(SINE_POINTS);
      d10_r <= (range_r == RANGE_X1000);
    end
  end

  assign tc1     = tick_r + TICK_W'(1);
  assign restart = 32'(tc1) >= 32'(k_r);
  assign fire    = !restart && (sub_r >= (d10_r ? SUB_DIV_HI : SUB_W'(1)));
  assign next9   = {1'b0, step_r} + (STEP_W+1)'(1);
  assign next_val = (next9 >= (STEP_W+1)'(n_r)) ? STEP_W'(n_r - N_W'(1)) : next9[STEP_W-1:0];

  assign adv = DVD_W'(time_r) >= quo;
  assign rom_idx = (quo >= DVD_W'(ROM_SIZE)) ? STEP_W'(ROM_SIZE - 1) : quo[STEP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      step_r  <= '0;
      sub_r   <= '0;
      time_r  <= '0;
      duty_r  <= DUTY_RESET;
      start_r <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        start_r <= 1'b0;
      end
      if (cmd.upd) begin
        // The sub-count goes back to one on a restart or a fire, and otherwise counts up by one.
        if (restart) begin
          tick_r  <= '0;
          step_r  <= '0;
          sub_r   <= SUB_W'(1);
          time_r  <= '0;
          duty_r  <= sine_at('0);
          start_r <= 1'b1;
        end else if (fire) begin
          tick_r <= tc1;
          sub_r  <= SUB_W'(1);
          time_r <= time_r + TIME_W'(1);
        end else begin
          tick_r <= tc1;
          sub_r  <= sub_r + SUB_W'(1);
        end
      end
      if (cmd.t_eval && adv) begin
        step_r <= next_r;
      end
      if (cmd.i_load) begin
        duty_r <= sine_at(rom_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      next_r <= next_val;
    end
  end

  assign tgt_prod = PROD_W'(k_r) * PROD_W'(next_r);
  assign idx_prod = IDX_W'(step_r) * IDX_W'(SINE_POINTS);

  assign div_start = cmd.k_start || cmd.t_start || cmd.i_start;

  always_comb begin
    priority if (cmd.k_start) begin
      div_dvd   = DVD_W'(num_for_range(range_r)) << (DVD_W - NUM_W);
      div_dsr   = DSR_W'(den);
      div_iters = CNT_W'(NUM_W);
    end else if (cmd.t_start) begin
      div_dvd   = DVD_W'(tgt_prod) << (DVD_W - PROD_W);
      div_dsr   = DSR_W'(nd);
      div_iters = CNT_W'(PROD_W);
    end else begin
      div_dvd   = DVD_W'(idx_prod) << (DVD_W - IDX_W);
      div_dsr   = DSR_W'(n_r);
      div_iters = CNT_W'(IDX_W);
    end
  end

  spdsq_div #(
    .DVD_W (DVD_W),
    .DSR_W (DSR_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .iters    (div_iters),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_duty_r  <= duty_r;
      out_start_r <= start_r;
      out_step_r  <= step_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty         = out_duty_r;
  assign out_period_start = out_start_r;
  assign out_step_index   = out_step_r;

  assign stat.k_valid  = k_valid_r;
  assign stat.fire     = fire;
  assign stat.adv      = adv;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  a_no_div_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_upd_needs_k: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> k_valid_r)
    else $error("tick processed without a valid period length");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && restart) |=> (step_r == '0) && (duty_r == SINE_ROM[0]) && start_r)
    else $error("period restart did not reset the sequencer");

  a_duty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.upd && !cmd.i_load) |=> $stable(duty_r))
    else $error("duty changed without an update");

endmodule

`default_nettype wire

>>> src/spdsq_ctrl.sv
`default_nettype none

module spdsq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_tick,
  output logic                   in_ready,
  input  spdsq_pkg::spdsq_stat_t stat,
  output spdsq_pkg::spdsq_cmd_t  cmd
);

  import spdsq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_KGO  = 9'b000000010,
    S_KDIV = 9'b000000100,
    S_UPD  = 9'b000001000,
    S_TGO  = 9'b000010000,
    S_TDIV = 9'b000100000,
    S_IGO  = 9'b001000000,
    S_IDIV = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.clr_start = 1'b1;
          if (!in_tick) begin
            state_nxt = S_DONE;
          end else if (stat.k_valid) begin
            state_nxt = S_UPD;
          end else begin
            state_nxt = S_KGO;
          end
        end
      end
      S_KGO: begin
        cmd.k_start = 1'b1;
        state_nxt   = S_KDIV;
      end
      S_KDIV: begin
        if (stat.div_done) begin
          cmd.k_load = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = stat.fire ? S_TGO : S_DONE;
      end
      S_TGO: begin
        cmd.t_start = 1'b1;
        state_nxt   = S_TDIV;
      end
      S_TDIV: begin
        if (stat.div_done) begin
          cmd.t_eval = 1'b1;
          state_nxt  = stat.adv ? S_IGO : S_DONE;
        end
      end
      S_IGO: begin
        cmd.i_start = 1'b1;
        state_nxt   = S_IDIV;
      end
      S_IDIV: begin
        if (stat.div_done) begin
          cmd.i_load = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/sine_pwm_duty_sequencer.sv
// A request with tick 0 only registers a result. A tick updates the counters; a tick that
// fires adds a step check, and a step that advances adds a sine index division.
// The first tick after reset or after a configuration write first derives the period
// length; all of these divisions share the one bit-serial divider.
// One request is in work at a time; the next is taken once the result is registered.
// Reset (rst_n low, synchronous) restores frequency 100, range x1, zero counters and duty 12.
`default_nettype none

module sine_pwm_duty_sequencer #(
  parameter int unsigned SINE_POINTS = spdsq_pkg::SINE_POINTS_DEF,
  parameter int unsigned PWM_PERIOD  = spdsq_pkg::PWM_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  spdsq_in_if.sink    in_chan,
  spdsq_out_if.source out_chan,
  spdsq_cfg_if.sink   cfg_chan
);

  import spdsq_pkg::*;

  spdsq_cmd_t  cmd;
  spdsq_stat_t stat;

  spdsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_tick  (in_chan.tick),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spdsq_dp #(
    .SINE_POINTS (SINE_POINTS),
    .PWM_PERIOD  (PWM_PERIOD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_chan.valid),
    .cfg_index        (cfg_chan.index),
    .cfg_data         (cfg_chan.data),
    .cfg_ready        (cfg_chan.ready),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_duty         (out_chan.duty),
    .out_period_start (out_chan.period_start),
    .out_step_index   (out_chan.step_index)
  );

endmodule

`default_nettype wire
